/* rtl/mpp_pkg.sv */
// ----------------------------------------------------------------------------
// mpp_pkg: shared types and constants of the masked pattern patcher
// Request and result structs, configuration registers, register indexes.
// ----------------------------------------------------------------------------
package mpp_pkg;

    localparam int PATTERN_MAX_DEF   = 8;
    localparam int POSITION_BITS_DEF = 32;
    localparam int Q_DEPTH           = 4;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 64;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BIT_MASK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATCH_BYTES      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATCH_BIT_MASK   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PATCH_LENGTH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PATCH_DISTANCE   = 3'd6;

    localparam logic [3:0] PATCH_MAX = 4'd8;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       found;
    } t_out_item;

    typedef struct packed {
        logic [63:0] pattern_bytes;
        logic [63:0] pattern_bit_mask;
        logic [3:0]  pattern_length;
        logic [63:0] patch_bytes;
        logic [63:0] patch_bit_mask;
        logic [3:0]  patch_length;
        logic [15:0] patch_distance;
    } t_cfg;

endpackage

/* rtl/mpp_fifo.sv */
// ----------------------------------------------------------------------------
// mpp_fifo: short queue between the scan front and the patch back
// Flop storage, one write and one read per cycle, read from the head.
// ----------------------------------------------------------------------------
module mpp_fifo #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

endmodule

/* rtl/mpp_front.sv */
// ----------------------------------------------------------------------------
// mpp_front: delay line, masked pattern match and end-of-stream flush
// Pushes one record per leaving byte: byte, distance from match start, flags.
// ----------------------------------------------------------------------------
module mpp_front #(
    parameter int PATTERN_MAX   = 8,
    parameter int POSITION_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  mpp_pkg::t_in_item         i_in_data,
    input  mpp_pkg::t_cfg             i_cfg,
    input  logic                      i_q_full,
    output logic                      o_push,
    output logic [POSITION_BITS+9:0]  o_rec
);
    import mpp_pkg::*;

    localparam int HW = $clog2(PATTERN_MAX + 1);
    localparam int IW = $clog2(PATTERN_MAX);
    localparam logic [HW-1:0] HELD_FULL = HW'(PATTERN_MAX);

    logic [7:0]               r_line [PATTERN_MAX];
    logic [7:0]               n_line [PATTERN_MAX];
    logic [HW-1:0]            r_held, n_held;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_mstart, n_mstart;
    logic                     r_seen, n_seen;
    logic                     r_flush, n_flush;

    logic                     w_accept;
    logic [HW-1:0]            w_len;
    logic [POSITION_BITS-1:0] w_diff;
    logic                     w_fin;

    // clamp pattern length to 1..PATTERN_MAX
    always_comb begin
        if (i_cfg.pattern_length == 4'd0) begin
            w_len = HW'(1);
        end else if (i_cfg.pattern_length > 4'(PATTERN_MAX)) begin
            w_len = HELD_FULL;
        end else begin
            w_len = HW'(i_cfg.pattern_length);
        end
    end

    assign o_in_stall = r_flush | i_q_full;
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign w_diff     = r_pos - POSITION_BITS'(r_held) - r_mstart;

    always_comb begin
        logic [HW-1:0] v_base;
        logic [HW-1:0] v_idx;
        logic          v_ok;
        logic [7:0]    v_m;

        n_line   = r_line;
        n_held   = r_held;
        n_pos    = r_pos;
        n_mstart = r_mstart;
        n_seen   = r_seen;
        n_flush  = r_flush;
        o_push   = 1'b0;
        w_fin    = 1'b0;
        v_base   = '0;
        v_idx    = '0;
        v_ok     = 1'b1;
        v_m      = '0;

        if (r_flush) begin
            if (!i_q_full) begin
                o_push = 1'b1;
                w_fin  = (r_held == HW'(1));
                for (int i = 0; i < PATTERN_MAX - 1; i++) begin
                    n_line[i] = r_line[i + 1];
                end
                n_held = r_held - 1'b1;
                if (r_held == HW'(1)) begin
                    // stream done: back to reset state
                    n_pos    = '0;
                    n_mstart = '0;
                    n_seen   = 1'b0;
                    n_flush  = 1'b0;
                end
            end
        end else if (w_accept) begin
            if (r_held == HELD_FULL) begin
                o_push = 1'b1;
                for (int i = 0; i < PATTERN_MAX - 1; i++) begin
                    n_line[i] = r_line[i + 1];
                end
                n_line[PATTERN_MAX - 1] = i_in_data.in_byte;
            end else begin
                n_line[r_held[IW-1:0]] = i_in_data.in_byte;
                n_held = r_held + 1'b1;
            end
            n_pos = r_pos + 1'b1;

            v_base = n_held - w_len;
            for (int j = 0; j < PATTERN_MAX; j++) begin
                v_idx = v_base + HW'(j);
                v_m   = i_cfg.pattern_bit_mask[8*j +: 8];
                if (HW'(j) < w_len) begin
                    if (((n_line[v_idx[IW-1:0]] ^ i_cfg.pattern_bytes[8*j +: 8]) & v_m)
                            != 8'd0) begin
                        v_ok = 1'b0;
                    end
                end
            end
            if (!r_seen && (n_held >= w_len) && v_ok) begin
                n_seen   = 1'b1;
                n_mstart = n_pos - POSITION_BITS'(w_len);
            end
            if (i_in_data.is_last) begin
                n_flush = 1'b1;
            end
        end
    end

    assign o_rec = {r_line[0], w_diff, r_seen, w_fin};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= '0;
            r_pos    <= '0;
            r_mstart <= '0;
            r_seen   <= 1'b0;
            r_flush  <= 1'b0;
        end else begin
            r_held   <= n_held;
            r_pos    <= n_pos;
            r_mstart <= n_mstart;
            r_seen   <= n_seen;
            r_flush  <= n_flush;
        end
    end

    always_ff @(posedge i_clk) begin
        r_line <= n_line;
    end

endmodule

/* rtl/mpp_back.sv */
// ----------------------------------------------------------------------------
// mpp_back: patch window check and masked byte replace
// Pops records from the queue into the output register.
// ----------------------------------------------------------------------------
module mpp_back #(
    parameter int POSITION_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mpp_pkg::t_cfg             i_cfg,
    input  logic                      i_q_valid,
    input  logic [POSITION_BITS+9:0]  i_rec,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output mpp_pkg::t_out_item        o_out_data
);
    import mpp_pkg::*;

    logic [7:0]               w_byte;
    logic [POSITION_BITS-1:0] w_diff;
    logic                     w_seen;
    logic                     w_fin;
    logic [3:0]               w_plen;
    logic [POSITION_BITS:0]   w_k;
    logic                     w_in_win;
    logic [7:0]               w_pv;
    logic [7:0]               w_pm;
    t_out_item                n_out;

    logic                     r_valid, n_valid;
    t_out_item                r_out;

    assign {w_byte, w_diff, w_seen, w_fin} = i_rec;

    assign w_plen   = (i_cfg.patch_length > PATCH_MAX) ? PATCH_MAX : i_cfg.patch_length;
    // top bit set means the byte lies before the patch window
    assign w_k      = {1'b0, w_diff} - (POSITION_BITS + 1)'(i_cfg.patch_distance);
    assign w_in_win = w_seen && !w_k[POSITION_BITS]
                      && (w_k[POSITION_BITS-1:0] < POSITION_BITS'(w_plen));
    assign w_pv     = i_cfg.patch_bytes[8*w_k[2:0] +: 8];
    assign w_pm     = i_cfg.patch_bit_mask[8*w_k[2:0] +: 8];

    always_comb begin
        n_out.out_byte = w_in_win ? ((w_pv & w_pm) | (w_byte & ~w_pm)) : w_byte;
        n_out.last     = w_fin;
        n_out.found    = w_fin & w_seen;
    end

    assign o_pop   = i_q_valid && (!r_valid || !i_out_stall);
    assign n_valid = o_pop ? 1'b1 : (r_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

endmodule

/* rtl/masked_pattern_patcher_unit.sv */
// Output path: a byte leaves the delay line when PATTERN_MAX later bytes have come in,
//   or at end of stream; its result then passes the queue and the output register.
// Throughput, given queue room: one request per cycle; a request marked last stalls input
//   while held bytes (up to PATTERN_MAX) flush one per cycle via the single queue write.
// Reset: synchronous, active low; state registers reset at once, no clearing pass.
// ----------------------------------------------------------------------------
// masked_pattern_patcher_unit: masked byte pattern search and replace
// Configuration registers, scan front, record queue and patch back.
// ----------------------------------------------------------------------------
module masked_pattern_patcher_unit #(
    parameter int PATTERN_MAX   = mpp_pkg::PATTERN_MAX_DEF,
    parameter int POSITION_BITS = mpp_pkg::POSITION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  mpp_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output mpp_pkg::t_out_item              o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mpp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mpp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mpp_pkg::*;

    localparam int REC_W = POSITION_BITS + 10;
    localparam t_cfg CFG_RESET = '{64'd0, 64'd0, 4'd1, 64'd0, 64'd0, 4'd0, 16'd0};

    t_cfg             r_cfg, n_cfg;
    logic             w_push;
    logic             w_pop;
    logic             w_q_full;
    logic             w_q_valid;
    logic [REC_W-1:0] w_rec_in;
    logic [REC_W-1:0] w_rec_out;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_PATTERN_BYTES:    n_cfg.pattern_bytes    = i_cfg_data;
                REG_PATTERN_BIT_MASK: n_cfg.pattern_bit_mask = i_cfg_data;
                REG_PATTERN_LENGTH:   n_cfg.pattern_length   = i_cfg_data[3:0];
                REG_PATCH_BYTES:      n_cfg.patch_bytes      = i_cfg_data;
                REG_PATCH_BIT_MASK:   n_cfg.patch_bit_mask   = i_cfg_data;
                REG_PATCH_LENGTH:     n_cfg.patch_length     = i_cfg_data[3:0];
                REG_PATCH_DISTANCE:   n_cfg.patch_distance   = i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    mpp_front #(
        .PATTERN_MAX   (PATTERN_MAX),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_cfg      (r_cfg),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_rec      (w_rec_in)
    );

    mpp_fifo #(
        .WIDTH (REC_W),
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_rec_in),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_data  (w_rec_out)
    );

    mpp_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_rec       (w_rec_out),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench of the masked pattern patcher unit
// Streams bytes through the unit under several register settings, predicts
// each output byte with a cycle-free shadow of the delay line, match search
// and patch window, and compares every output byte with the prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import mpp_pkg::*;

    localparam int LINE_DEPTH    = PATTERN_MAX_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    typedef enum int {
        STREAM_NOISE,
        STREAM_BROKEN,
        STREAM_CLEAN
    } t_stream_kind;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // shadow of the register file and of the stream state
    t_cfg        cfg_shadow;
    logic [7:0]  line_bytes [LINE_DEPTH];
    int          line_held;
    logic [31:0] line_pos;
    logic        line_matched;
    logic [31:0] match_at;

    t_out_item   pending_bytes [$];

    int in_idle_pct = 0;
    int out_idle_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int mismatch_count = 0;
    int bytes_sent = 0;
    int bytes_checked = 0;
    int streams_sent = 0;
    int streams_found = 0;
    int cfg_writes = 0;

    masked_pattern_patcher_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic void clear_line();
        for (int i = 0; i < LINE_DEPTH; i++) line_bytes[i] = 8'h00;
        line_held    = 0;
        line_pos     = '0;
        line_matched = 1'b0;
        match_at     = '0;
    endfunction

    function automatic void cfg_apply(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        case (idx)
            REG_PATTERN_BYTES:    cfg_shadow.pattern_bytes    = data;
            REG_PATTERN_BIT_MASK: cfg_shadow.pattern_bit_mask = data;
            REG_PATTERN_LENGTH:   cfg_shadow.pattern_length   = data[3:0];
            REG_PATCH_BYTES:      cfg_shadow.patch_bytes      = data;
            REG_PATCH_BIT_MASK:   cfg_shadow.patch_bit_mask   = data;
            REG_PATCH_LENGTH:     cfg_shadow.patch_length     = data[3:0];
            REG_PATCH_DISTANCE:   cfg_shadow.patch_distance   = data[15:0];
            default: ;
        endcase
    endfunction

    function automatic int used_pattern_len();
        if (cfg_shadow.pattern_length == 0) return 1;
        if (cfg_shadow.pattern_length > LINE_DEPTH) return LINE_DEPTH;
        return int'(cfg_shadow.pattern_length);
    endfunction

    function automatic logic [7:0] patched_byte(logic [7:0] b, logic [31:0] pos);
        logic [31:0] diff;
        logic [31:0] k;
        int          plen;
        logic [7:0]  v;
        logic [7:0]  m;
        if (!line_matched) return b;
        plen = (cfg_shadow.patch_length > PATCH_MAX) ? 8 : int'(cfg_shadow.patch_length);
        diff = pos - match_at;
        if (diff < {16'h0000, cfg_shadow.patch_distance}) return b;
        k = diff - {16'h0000, cfg_shadow.patch_distance};
        if (k >= plen) return b;
        v = cfg_shadow.patch_bytes[8*k +: 8];
        m = cfg_shadow.patch_bit_mask[8*k +: 8];
        return (v & m) | (b & ~m);
    endfunction

    function automatic void emit_oldest(logic fin);
        t_out_item r;
        r.out_byte = patched_byte(line_bytes[0], line_pos - line_held);
        r.last     = fin;
        r.found    = fin & line_matched;
        if (r.found) streams_found++;
        pending_bytes.push_back(r);
        for (int i = 0; i < LINE_DEPTH - 1; i++) line_bytes[i] = line_bytes[i+1];
        line_bytes[LINE_DEPTH-1] = 8'h00;
        line_held--;
    endfunction

    function automatic void scan_and_patch(t_in_item item);
        int   len;
        int   base;
        logic hit;
        logic [7:0] m;
        len = used_pattern_len();
        if (line_held >= LINE_DEPTH) emit_oldest(1'b0);
        line_bytes[line_held] = item.in_byte;
        line_held++;
        line_pos++;
        if (!line_matched && line_held >= len) begin
            base = line_held - len;
            hit  = 1'b1;
            for (int j = 0; j < len; j++) begin
                m = cfg_shadow.pattern_bit_mask[8*j +: 8];
                if ((line_bytes[base+j] & m) != (cfg_shadow.pattern_bytes[8*j +: 8] & m))
                    hit = 1'b0;
            end
            if (hit) begin
                line_matched = 1'b1;
                match_at     = line_pos - len;
            end
        end
        if (item.is_last) begin
            while (line_held > 0) emit_oldest(line_held == 1);
            clear_line();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : check_result
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch("unexpected out_byte", int'(o_out_data.out_byte), 0);
            end else begin
                want = pending_bytes.pop_front();
                if (o_out_data.out_byte !== want.out_byte)
                    report_mismatch("out_byte", int'(o_out_data.out_byte),
                                    int'(want.out_byte));
                if (o_out_data.last !== want.last)
                    report_mismatch("last", int'(o_out_data.last), int'(want.last));
                if (o_out_data.found !== want.found)
                    report_mismatch("found", int'(o_out_data.found), int'(want.found));
                bytes_checked++;
            end
        end
    end

    // receiver: random stalls, or a counted hold when one is requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_bytes.size());
            $display("[masked_pattern_patcher_unit] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_byte(logic [7:0] b, logic fin);
        t_in_item item;
        item.in_byte = b;
        item.is_last = fin;
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        scan_and_patch(item);
        bytes_sent++;
        if (fin) streams_sent++;
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // drop valid, drain every expected result, then let the pipeline go quiet
    task automatic settle();
        release_input();
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_apply(idx, data);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_stream(logic [7:0] s[$], int from, int upto, logic close);
        for (int i = from; i <= upto; i++) send_byte(s[i], close && (i == upto));
    endtask

    function automatic void make_stream(int n, t_stream_kind kind, output logic [7:0] s[$]);
        int plen;
        int at;
        int j;
        logic [7:0] m;
        s = {};
        for (int i = 0; i < n; i++) s.push_back(8'($urandom_range(255)));
        plen = used_pattern_len();
        if (kind != STREAM_NOISE && n >= plen) begin
            at = $urandom_range(n - plen);
            for (int i = 0; i < plen; i++) begin
                m = cfg_shadow.pattern_bit_mask[8*i +: 8];
                s[at+i] = (cfg_shadow.pattern_bytes[8*i +: 8] & m) | (s[at+i] & ~m);
            end
            if (kind == STREAM_BROKEN) begin
                // flip the lowest compared bit of one pattern byte
                j = $urandom_range(plen - 1);
                m = cfg_shadow.pattern_bit_mask[8*j +: 8];
                s[at+j] = s[at+j] ^ (m & (~m + 8'd1));
            end
        end
    endfunction

    task automatic randomize_config();
        logic [63:0] junk;
        logic [3:0]  len;
        junk = {$urandom, $urandom};
        write_reg(REG_PATTERN_BYTES, {$urandom, $urandom});
        case ($urandom_range(7))
            0, 1, 2, 3: write_reg(REG_PATTERN_BIT_MASK, '1);
            6:          write_reg(REG_PATTERN_BIT_MASK, '0);
            default:    write_reg(REG_PATTERN_BIT_MASK, {$urandom, $urandom});
        endcase
        len = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8, 0));
        write_reg(REG_PATTERN_LENGTH, {junk[63:4], len});
        write_reg(REG_PATCH_BYTES, {$urandom, $urandom});
        write_reg(REG_PATCH_BIT_MASK, $urandom_range(1) ? '1 : {$urandom, $urandom});
        len = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8, 0));
        write_reg(REG_PATCH_LENGTH, {junk[3:0], junk[63:8], len});
        write_reg(REG_PATCH_DISTANCE,
                  {junk[47:0], ($urandom_range(4) == 0) ? 16'($urandom_range(65535))
                                                        : 16'($urandom_range(10))});
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // reset values: one-byte pattern with no compared bits matches at once
    task automatic test_reset_defaults();
        send_byte(8'hFF, 1'b1);
    endtask

    // eight-byte pattern and patch, both lengths above range, match on the last byte
    task automatic test_full_window();
        logic [7:0] s[$];
        settle();
        write_reg(REG_PATTERN_BYTES, 64'hFF00_7E81_C33C_00FF);
        write_reg(REG_PATTERN_BIT_MASK, '1);
        write_reg(REG_PATTERN_LENGTH, 64'hF);
        write_reg(REG_PATCH_BYTES, 64'h1122_3344_5566_7788);
        write_reg(REG_PATCH_BIT_MASK, 64'hF0F0_FFFF_0000_FF0F);
        write_reg(REG_PATCH_LENGTH, 64'hF);
        write_reg(REG_PATCH_DISTANCE, 64'h0);
        make_stream(8, STREAM_CLEAN, s);
        send_stream(s, 0, 7, 1'b1);
    endtask

    // zero pattern length, second match ignored, patch window runs off the end
    task automatic test_tail_drop();
        logic [7:0] s[$];
        settle();
        write_reg(REG_PATTERN_LENGTH, 64'h0);
        write_reg(REG_PATTERN_BYTES, 64'h0);
        write_reg(REG_PATTERN_BIT_MASK, 64'hFF);
        write_reg(REG_PATCH_BYTES, 64'hAA_BBCC);
        write_reg(REG_PATCH_BIT_MASK, '1);
        write_reg(REG_PATCH_LENGTH, 64'h3);
        write_reg(REG_PATCH_DISTANCE, 64'h2);
        s = {8'hA5, 8'h00, 8'h00, 8'h11, 8'h22};
        send_stream(s, 0, 4, 1'b1);
    endtask

    // pattern split across the stream never lines up; widest patch distance
    task automatic test_no_match();
        logic [7:0] s[$];
        settle();
        write_reg(REG_NONE, '1);
        write_reg(REG_PATTERN_LENGTH, 64'h2);
        write_reg(REG_PATTERN_BYTES, 64'hADDE);
        write_reg(REG_PATTERN_BIT_MASK, 64'hFFFF);
        write_reg(REG_PATCH_DISTANCE, 64'hFFFF);
        write_reg(REG_PATCH_LENGTH, 64'h8);
        s = {8'hDE, 8'hBE, 8'hEF, 8'hAD};
        send_stream(s, 0, 3, 1'b1);
    endtask

    task automatic test_random_streams(int count);
        logic [7:0]   s[$];
        int           stop_at;
        int           n;
        int           pick;
        t_stream_kind kind;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(1)) begin
                settle();
                randomize_config();
            end
            n    = ($urandom_range(7) == 0) ? $urandom_range(45, 24) : $urandom_range(16, 1);
            // trim the last stream to the byte budget
            if (n > stop_at - bytes_sent) n = stop_at - bytes_sent;
            pick = $urandom_range(9);
            kind = (pick < 2) ? STREAM_NOISE : (pick < 4) ? STREAM_BROKEN : STREAM_CLEAN;
            make_stream(n, kind, s);
            send_stream(s, 0, n - 1, 1'b1);
        end
    endtask

    // hold the output long enough to fill the unit, then pause mid-stream to drain
    task automatic test_backpressure();
        logic [7:0] s[$];
        settle();
        randomize_config();
        make_stream(30, STREAM_CLEAN, s);
        hold_left = 120;
        send_stream(s, 0, 13, 1'b0);
        settle();
        send_stream(s, 14, 29, 1'b1);
    endtask

    initial begin
        cfg_shadow = '0;
        cfg_shadow.pattern_length = 4'd1;
        clear_line();
        in_idle_pct  = 38;
        out_idle_pct = 78;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_full_window();
        test_tail_drop();
        test_no_match();
        test_random_streams(20);

        in_idle_pct  = 78;
        out_idle_pct = 38;
        test_random_streams(20);

        in_idle_pct  = 0;
        out_idle_pct = 0;
        test_backpressure();
        test_random_streams(12);

        settle();
        $display("covered %0d bytes in %0d streams (%0d with a match), %0d register writes",
                 bytes_sent, streams_sent, streams_found, cfg_writes);
        $display("checked %0d output bytes, %0d mismatches", bytes_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("[masked_pattern_patcher_unit] OK");
        end else begin
            $display("[masked_pattern_patcher_unit] ERROR");
        end
        $finish;
    end

endmodule
